// ===== design/lsharp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsharp_pkg
// Shared types, register indexes and arithmetic helpers of the RGB Laplacian
// sharpening block.
// ----------------------------------------------------------------------------
package lsharp_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SHARPEN_GAIN = 2'd2
    } cfg_reg_t;

    localparam int CFG_DATA_W = 12;
    localparam int DIM_W      = 12;
    localparam int GAIN_W     = 8;
    localparam int ROW_W      = 13;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int LAP_W      = 11;
    localparam int PROD_W     = 20;

    localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 12'd480;
    localparam logic [GAIN_W-1:0] SHARPEN_GAIN_RST = 8'd128;

    // Position flags of the pixel that reaches the window centre
    typedef struct packed {
        logic emit;
        logic no_up;
        logic no_dn;
        logic no_lf;
        logic no_rt;
        logic last;
    } pos_t;

    // Clamp a signed sum to the unsigned 8-bit pixel range
    function automatic logic [CHAN_W-1:0] sat_u8(input logic signed [PROD_W-1:0] v);
        logic [CHAN_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > PROD_W'(signed'(255))) begin
            res = 8'hFF;
        end else begin
            res = v[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/laplace_sharpen_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplace_sharpen_rgb
// Streaming 3x3 four-neighbour Laplacian sharpening of RGB pixels with zero
// padding, gain and saturation, built around one dual-row line memory.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the s_ channel (valid/ready). After each
//   frame the source sends frame_width + 1 items with s_filler set to drain
//   the last row. Results leave on the m_ channel; m_frame_end marks the last
//   pixel of a frame. The first frame_width + 1 items of a frame give no result.
//   Path: the item that completes a window (the pixel's raster successor one
//   row down) moves through the s1 to s4 registers into the output register.
//   Throughput: one item per clock when not frozen; the line memory takes
//   one read and one write each cycle, the write trailing the read by one
//   stage with a bypass register for back-to-back hits on the same column.
//   Stall: when the output register holds an untaken result and another result
//   is ready behind it, the pipeline freezes and s_ready drops; otherwise input
//   keeps flowing while m_valid waits.
//   Reset (aresetn low, synchronous) clears the counters, window and valid
//   flags and restores the register defaults (640 x 480, gain 128). The line
//   memory is not cleared: rows read before being written are padded away.
//   Configuration writes on cfg_ are always accepted; change them only while
//   the block is idle.
// ----------------------------------------------------------------------------
module laplace_sharpen_rgb
    import lsharp_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAN_W-1:0]     s_blue_in,
    input  logic [CHAN_W-1:0]     s_green_in,
    input  logic [CHAN_W-1:0]     s_red_in,
    input  logic                  s_filler,
    // pixel output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAN_W-1:0]     m_blue_out,
    output logic [CHAN_W-1:0]     m_green_out,
    output logic [CHAN_W-1:0]     m_red_out,
    output logic                  m_frame_end
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > DIM_W) ? WW : DIM_W;
    localparam int MDW = 2 * PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [GAIN_W-1:0] sharpen_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            sharpen_gain_reg <= SHARPEN_GAIN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_SHARPEN_GAIN: sharpen_gain_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic pipe_en;
    logic s_fire;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic m_valid_reg;

    // Freeze only when a result must move into a still occupied output
    assign pipe_en = !(m_valid_reg && !m_ready && s4_valid_reg);
    assign s_ready = pipe_en;
    assign s_fire  = s_valid && pipe_en;

    // ------------------------------------------------------------------
    // Stage 0: position counters and border flags
    // ------------------------------------------------------------------
    logic [AW-1:0]    column_reg;
    logic [ROW_W-1:0] row_reg;
    logic [AW-1:0]    column_next;
    logic [ROW_W-1:0] row_next;
    logic [EW-1:0]    eff_w;
    logic [EW-1:0]    width_ext;
    logic [ROW_W-1:0] eff_h;
    logic [EW-1:0]    col_inc;
    logic [EW-1:0]    pc;
    logic [ROW_W-1:0] pr;
    logic             have;
    pos_t             pos0;
    logic [PIX_W-1:0] px0;

    always_comb begin
        width_ext = EW'(frame_width_reg);
        if (width_ext == '0) begin
            eff_w = EW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = width_ext;
        end
        eff_h = (frame_height_reg == '0) ? ROW_W'(1) : ROW_W'(frame_height_reg);

        col_inc = EW'(column_reg) + EW'(1);

        // locate the pixel that the new column puts at the window centre
        if (column_reg != '0) begin
            have = (row_reg >= ROW_W'(1));
            pr   = row_reg - ROW_W'(1);
            pc   = EW'(column_reg) - EW'(1);
        end else begin
            have = (row_reg >= ROW_W'(2));
            pr   = row_reg - ROW_W'(2);
            pc   = eff_w - EW'(1);
        end

        pos0.emit  = have && (pr < eff_h);
        pos0.no_up = (pr == '0);
        pos0.no_dn = ((pr + ROW_W'(1)) >= eff_h);
        pos0.no_lf = (pc == '0);
        pos0.no_rt = ((pc + EW'(1)) >= eff_w);
        pos0.last  = ((pr + ROW_W'(1)) == eff_h) && pos0.no_rt;

        // advance position; wrap the frame after the drain
        if (row_reg >= (eff_h + ROW_W'(1))) begin
            column_next = '0;
            row_next    = '0;
        end else if (col_inc >= eff_w) begin
            column_next = '0;
            row_next    = row_reg + ROW_W'(1);
        end else begin
            column_next = col_inc[AW-1:0];
            row_next    = row_reg;
        end

        px0 = s_filler ? '0 : {s_red_in, s_green_in, s_blue_in};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else if (s_fire) begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: {upper row, middle row} per column
    // ------------------------------------------------------------------
    logic [MDW-1:0] line_mem [MAX_WIDTH];
    logic [MDW-1:0] rd_data_reg;

    logic [AW-1:0]    s1_addr_reg;
    logic [PIX_W-1:0] s1_px_reg;
    pos_t             s1_pos_reg;

    logic             fw_valid_reg;
    logic [AW-1:0]    fw_addr_reg;
    logic [MDW-1:0]   fw_data_reg;

    logic             s1_fire;
    logic [MDW-1:0]   line_cur;
    logic [MDW-1:0]   line_wr;
    logic [PIX_W-1:0] upper_cur;
    logic [PIX_W-1:0] middle_cur;

    assign s1_fire = pipe_en && s1_valid_reg;

    // bypass the latest write when it hits the column being read
    always_comb begin
        if (fw_valid_reg && (fw_addr_reg == s1_addr_reg)) begin
            line_cur = fw_data_reg;
        end else begin
            line_cur = rd_data_reg;
        end
        upper_cur  = line_cur[MDW-1:PIX_W];
        middle_cur = line_cur[PIX_W-1:0];
        line_wr    = {middle_cur, s1_px_reg};
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rd_data_reg <= line_mem[column_reg];
        end
        if (s1_fire) begin
            line_mem[s1_addr_reg] <= line_wr;
        end
    end

    // Stage 1 payload and bypass contents
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_addr_reg <= column_reg;
            s1_px_reg   <= px0;
            s1_pos_reg  <= pos0;
        end
        if (s1_fire) begin
            fw_addr_reg <= s1_addr_reg;
            fw_data_reg <= line_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            fw_valid_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the 3x3 window and pick the masked taps
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = upper_cur;
        win_next[1][2] = middle_cur;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (s1_fire) begin
            win_reg <= win_next;
        end
    end

    logic [PIX_W-1:0] s2_ctr_reg;
    logic [PIX_W-1:0] s2_up_reg;
    logic [PIX_W-1:0] s2_dn_reg;
    logic [PIX_W-1:0] s2_lf_reg;
    logic [PIX_W-1:0] s2_rt_reg;
    logic             s2_last_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_ctr_reg  <= win_next[1][1];
            s2_up_reg   <= s1_pos_reg.no_up ? '0 : win_next[0][1];
            s2_dn_reg   <= s1_pos_reg.no_dn ? '0 : win_next[2][1];
            s2_lf_reg   <= s1_pos_reg.no_lf ? '0 : win_next[1][0];
            s2_rt_reg   <= s1_pos_reg.no_rt ? '0 : win_next[1][2];
            s2_last_reg <= s1_pos_reg.last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Laplacian per channel
    // ------------------------------------------------------------------
    logic signed [LAP_W-1:0]  lap2 [3];
    logic signed [LAP_W-1:0]  s3_lap_reg [3];
    logic        [CHAN_W-1:0] s3_ctr_reg [3];
    logic                     s3_last_reg;

    always_comb begin
        logic [LAP_W-1:0] nsum;
        logic [LAP_W-1:0] ctr4;
        for (int k = 0; k < 3; k++) begin
            nsum = LAP_W'(s2_up_reg[k*CHAN_W +: CHAN_W])
                 + LAP_W'(s2_dn_reg[k*CHAN_W +: CHAN_W])
                 + LAP_W'(s2_lf_reg[k*CHAN_W +: CHAN_W])
                 + LAP_W'(s2_rt_reg[k*CHAN_W +: CHAN_W]);
            ctr4 = {1'b0, s2_ctr_reg[k*CHAN_W +: CHAN_W], 2'b00};
            lap2[k] = signed'(nsum - ctr4);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                s3_lap_reg[k] <= lap2[k];
                s3_ctr_reg[k] <= s2_ctr_reg[k*CHAN_W +: CHAN_W];
            end
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: apply gain
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] s4_prod_reg [3];
    logic        [CHAN_W-1:0] s4_ctr_reg  [3];
    logic                     s4_last_reg;
    logic signed [GAIN_W:0]   gain_s;

    assign gain_s = signed'({1'b0, sharpen_gain_reg});

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                s4_prod_reg[k] <= PROD_W'(gain_s * s3_lap_reg[k]);
                s4_ctr_reg[k]  <= s3_ctr_reg[k];
            end
            s4_last_reg <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: add centre, saturate, load output register
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] res4 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            res4[k] = sat_u8(s4_prod_reg[k] + signed'(PROD_W'(s4_ctr_reg[k])));
        end
    end

    logic [CHAN_W-1:0] m_blue_reg;
    logic [CHAN_W-1:0] m_green_reg;
    logic [CHAN_W-1:0] m_red_reg;
    logic              m_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en && s4_valid_reg) begin
            m_blue_reg      <= res4[0];
            m_green_reg     <= res4[1];
            m_red_reg       <= res4[2];
            m_frame_end_reg <= s4_last_reg;
        end
    end

    // Valid flags: only items that complete a window go past stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (pipe_en) begin
                s1_valid_reg <= s_valid;
                s2_valid_reg <= s1_valid_reg && s1_pos_reg.emit;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
            end
            if (pipe_en && s4_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_blue_out  = m_blue_reg;
    assign m_green_out = m_green_reg;
    assign m_red_out   = m_red_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

// ===== design/lsharp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsharp_chk
// Port-level checks of the sharpening block, bound to its top level.
// ----------------------------------------------------------------------------
module lsharp_chk
    import lsharp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [CHAN_W-1:0]     s_blue_in,
    input logic [CHAN_W-1:0]     s_green_in,
    input logic [CHAN_W-1:0]     s_red_in,
    input logic                  s_filler,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [CHAN_W-1:0]     m_blue_out,
    input logic [CHAN_W-1:0]     m_green_out,
    input logic [CHAN_W-1:0]     m_red_out,
    input logic                  m_frame_end
);

    // Hold a stalled result and its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid
            && $stable({m_blue_out, m_green_out, m_red_out, m_frame_end}))
        else $error("stalled result changed or dropped");

    // Hold an offered pixel until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid
            && $stable({s_blue_in, s_green_in, s_red_in, s_filler}))
        else $error("offered pixel changed or withdrawn");

    // Drop s_ready only under back-pressure from a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // Clear the output after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Accept configuration writes in every cycle
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind laplace_sharpen_rgb lsharp_chk u_lsharp_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_blue_in   (s_blue_in),
    .s_green_in  (s_green_in),
    .s_red_in    (s_red_in),
    .s_filler    (s_filler),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_blue_out  (m_blue_out),
    .m_green_out (m_green_out),
    .m_red_out   (m_red_out),
    .m_frame_end (m_frame_end)
);

// ===== test/lsharp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsharp_checker
// Passive scoreboard for the RGB Laplacian sharpening block. It follows the
// configuration writes and every accepted pixel, keeps its own line rows and
// 3x3 window, and queues the sharpened pixel each transaction should give.
// Output transactions are compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module lsharp_checker
    import lsharp_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [CHAN_W-1:0]     s_blue_in,
    input  logic [CHAN_W-1:0]     s_green_in,
    input  logic [CHAN_W-1:0]     s_red_in,
    input  logic                  s_filler,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [CHAN_W-1:0]     m_blue_out,
    input  logic [CHAN_W-1:0]     m_green_out,
    input  logic [CHAN_W-1:0]     m_red_out,
    input  logic                  m_frame_end,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              frame_end;
    } sharp_pix_t;

    logic [DIM_W-1:0]  width_cfg;
    logic [DIM_W-1:0]  height_cfg;
    logic [GAIN_W-1:0] gain_cfg;

    logic [PIX_W-1:0]  upper_row  [MAX_WIDTH];
    logic [PIX_W-1:0]  middle_row [MAX_WIDTH];
    logic [PIX_W-1:0]  window_px  [3][3];
    int unsigned       col_pos;
    int unsigned       row_pos;

    sharp_pix_t        sharp_q [$];
    int                mismatches = 0;

    function automatic int chan_of(input logic [PIX_W-1:0] px, input int k);
        return int'(px[CHAN_W*k +: CHAN_W]);
    endfunction

    // gain * (up + down + left + right - 4 * centre) + centre, clamped to 0..255
    function automatic logic [CHAN_W-1:0] sharpen_chan(input int gain, input int ctr,
                                                       input int up, input int dn,
                                                       input int lf, input int rt);
        int lap;
        int v;
        lap = up + dn + lf + rt - 4 * ctr;
        v   = gain * lap + ctr;
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return CHAN_W'(v);
    endfunction

    // Shift one pixel into the window and queue the result for the centre pixel
    task automatic slide_window(input logic [PIX_W-1:0] px);
        int unsigned       w_eff;
        int unsigned       h_eff;
        int unsigned       idx;
        int unsigned       ctr_row;
        int unsigned       ctr_col;
        logic              has_ctr;
        logic              no_up;
        logic              no_dn;
        logic              no_lf;
        logic              no_rt;
        logic [CHAN_W-1:0] lvl [3];
        sharp_pix_t        want;

        w_eff = (width_cfg == 0) ? 1 : ((width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg);
        h_eff = (height_cfg == 0) ? 1 : height_cfg;
        idx   = col_pos % MAX_WIDTH;

        for (int i = 0; i < 3; i++) begin
            window_px[i][0] = window_px[i][1];
            window_px[i][1] = window_px[i][2];
        end
        window_px[0][2] = upper_row[idx];
        window_px[1][2] = middle_row[idx];
        window_px[2][2] = px;
        upper_row[idx]  = middle_row[idx];
        middle_row[idx] = px;

        // locate the pixel now sitting at the window centre
        if (col_pos >= 1) begin
            has_ctr = (row_pos >= 1);
            ctr_row = has_ctr ? row_pos - 1 : 0;
            ctr_col = col_pos - 1;
        end else begin
            has_ctr = (row_pos >= 2);
            ctr_row = has_ctr ? row_pos - 2 : 0;
            ctr_col = w_eff - 1;
        end

        if (has_ctr && ctr_row < h_eff) begin
            no_up = (ctr_row == 0);
            no_dn = (ctr_row + 1 >= h_eff);
            no_lf = (ctr_col == 0);
            no_rt = (ctr_col + 1 >= w_eff);
            for (int k = 0; k < 3; k++) begin
                lvl[k] = sharpen_chan(int'(gain_cfg), chan_of(window_px[1][1], k),
                                      no_up ? 0 : chan_of(window_px[0][1], k),
                                      no_dn ? 0 : chan_of(window_px[2][1], k),
                                      no_lf ? 0 : chan_of(window_px[1][0], k),
                                      no_rt ? 0 : chan_of(window_px[1][2], k));
            end
            want.blue      = lvl[0];
            want.green     = lvl[1];
            want.red       = lvl[2];
            want.frame_end = (ctr_row + 1 == h_eff) && (ctr_col + 1 >= w_eff);
            sharp_q.push_back(want);
        end

        // advance the raster position, wrapping after the last drain item
        if (row_pos >= h_eff + 1) begin
            col_pos = 0;
            row_pos = 0;
        end else if (col_pos + 1 >= w_eff) begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge aclk) begin
        sharp_pix_t got;
        sharp_pix_t want;
        if (!aresetn) begin
            width_cfg  = FRAME_WIDTH_RST;
            height_cfg = FRAME_HEIGHT_RST;
            gain_cfg   = SHARPEN_GAIN_RST;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            window_px = '{default: '0};
            col_pos   = 0;
            row_pos   = 0;
            sharp_q.delete();
        end else begin
            // compare first, so a pixel taken on this edge cannot match itself
            if (m_valid && m_ready) begin
                got = '{m_blue_out, m_green_out, m_red_out, m_frame_end};
                if (sharp_q.size() == 0) begin
                    $display("%0t: unexpected output b=%0d g=%0d r=%0d end=%0b",
                             $time, got.blue, got.green, got.red, got.frame_end);
                    mismatches++;
                end else begin
                    want = sharp_q.pop_front();
                    if (got.blue !== want.blue || got.green !== want.green ||
                        got.red !== want.red || got.frame_end !== want.frame_end) begin
                        $display("%0t: expected %0d %0d %0d %0b got %0d %0d %0d %0b",
                                 $time, want.blue, want.green, want.red, want.frame_end,
                                 got.blue, got.green, got.red, got.frame_end);
                        mismatches++;
                    end
                end
            end

            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_cfg  = cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: height_cfg = cfg_data[DIM_W-1:0];
                    REG_SHARPEN_GAIN: gain_cfg   = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // a filler stands for a zero pixel
            if (s_valid && s_ready) begin
                slide_window(s_filler ? '0 : {s_red_in, s_green_in, s_blue_in});
            end
        end
        fail_count  <= mismatches;
        outstanding <= sharp_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the RGB Laplacian sharpening block. Frames of many
// shapes and gains are streamed through with drain fillers, random gaps on
// both channels, a long output hold-off and pauses for the pipeline to empty.
// Checking is left to lsharp_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import lsharp_pkg::*;

    localparam int MAX_WIDTH    = 2048;
    localparam int RANDOM_ITEMS = 320;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_GAP     = 10;
    localparam int STALL_LIMIT  = 3000;

    typedef enum int {
        TONE_RANDOM,
        TONE_EXTREME,
        TONE_FLAT
    } tone_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [CHAN_W-1:0]     s_blue_in;
    logic [CHAN_W-1:0]     s_green_in;
    logic [CHAN_W-1:0]     s_red_in;
    logic                  s_filler;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAN_W-1:0]     m_blue_out;
    logic [CHAN_W-1:0]     m_green_out;
    logic [CHAN_W-1:0]     m_red_out;
    logic                  m_frame_end;

    int fail_count;
    int outstanding;
    int items_sent   = 0;
    int hold_asks    = 0;
    int holds_served = 0;
    int idle_cycles  = 0;
    bit steady       = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    laplace_sharpen_rgb #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_blue_in   (s_blue_in),
        .s_green_in  (s_green_in),
        .s_red_in    (s_red_in),
        .s_filler    (s_filler),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_blue_out  (m_blue_out),
        .m_green_out (m_green_out),
        .m_red_out   (m_red_out),
        .m_frame_end (m_frame_end)
    );

    lsharp_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_blue_in   (s_blue_in),
        .s_green_in  (s_green_in),
        .s_red_in    (s_red_in),
        .s_filler    (s_filler),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_blue_out  (m_blue_out),
        .m_green_out (m_green_out),
        .m_red_out   (m_red_out),
        .m_frame_end (m_frame_end),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Abort when no transaction of any kind moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side: random back-pressure, plus a long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != holds_served) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served++;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 11);
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Offer one pixel transaction and hold it until taken
    task automatic send_item(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] r, input logic f);
        if (!steady && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_blue_in  <= b;
        s_green_in <= g;
        s_red_in   <= r;
        s_filler   <= f;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stop offering and wait until every queued result has come out
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    function automatic logic [CHAN_W-1:0] pick_level(input tone_t tone);
        logic [CHAN_W-1:0] lvl;
        case (tone)
            TONE_EXTREME: lvl = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            TONE_FLAT:    lvl = CHAN_W'(96 + $urandom_range(7));
            default:      lvl = CHAN_W'($urandom_range(255));
        endcase
        return lvl;
    endfunction

    // One frame of w x h pixels followed by w + 1 drain transactions
    task automatic run_frame(input int w, input int h, input tone_t tone, input bit pause_mid);
        int n_pix;
        n_pix = w * h;
        for (int i = 0; i < n_pix; i++) begin
            if (pause_mid && i == n_pix / 2) begin
                wait_results();
            end
            if ($urandom_range(99) < 3) begin
                send_item(pick_level(TONE_RANDOM), pick_level(TONE_RANDOM),
                          pick_level(TONE_RANDOM), 1'b1);
            end else begin
                send_item(pick_level(tone), pick_level(tone), pick_level(tone), 1'b0);
            end
        end
        // drain; some transactions carry stray pixel data that must be padded away
        for (int i = 0; i <= w; i++) begin
            send_item(pick_level(TONE_RANDOM), pick_level(TONE_RANDOM),
                      pick_level(TONE_RANDOM), ($urandom_range(99) >= 15));
        end
    endtask

    task automatic run_phase(input int raw_w, input int raw_h, input int gain,
                             input int frames, input tone_t tone, input bit pause_mid);
        int w_eff;
        int h_eff;
        w_eff = (raw_w == 0) ? 1 : ((raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w);
        h_eff = (raw_h == 0) ? 1 : raw_h;
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(raw_w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(raw_h));
        // upper data bits lie outside the gain register
        write_reg(REG_SHARPEN_GAIN, {4'($urandom_range(15)), 8'(gain)});
        for (int i = 0; i < frames; i++) begin
            run_frame(w_eff, h_eff, tone, pause_mid && i == 0);
        end
        wait_idle();
    endtask

    initial begin
        int    phase_no;
        int    base_items;
        int    sel;
        int    raw_w;
        int    raw_h;
        int    gain;
        bit    pause_mid;
        tone_t tone;

        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_FRAME_WIDTH;
        cfg_data   <= '0;
        s_valid    <= 1'b0;
        s_blue_in  <= '0;
        s_green_in <= '0;
        s_red_in   <= '0;
        s_filler   <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset width and gain: one 640-pixel row
        write_reg(REG_FRAME_HEIGHT, 12'd1);
        run_frame(640, 1, TONE_RANDOM, 1'b0);
        wait_idle();

        // 3x3 frame with extreme values, a filler in the centre, stray drain data
        write_reg(REG_FRAME_WIDTH, 12'd3);
        write_reg(REG_FRAME_HEIGHT, 12'd3);
        write_reg(REG_SHARPEN_GAIN, 12'd1);
        send_item(8'hFF, 8'h00, 8'h80, 1'b0);
        send_item(8'h00, 8'hFF, 8'h01, 1'b0);
        send_item(8'hFF, 8'h00, 8'hFE, 1'b0);
        send_item(8'h00, 8'hFF, 8'h7F, 1'b0);
        send_item(8'hAA, 8'h55, 8'hFF, 1'b1);
        send_item(8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_item(8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        send_item(8'h12, 8'h34, 8'h56, 1'b0);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        wait_idle();

        // zero width and height act as a single pixel; top gain
        write_reg(REG_FRAME_WIDTH, 12'd0);
        write_reg(REG_FRAME_HEIGHT, 12'd0);
        write_reg(REG_SHARPEN_GAIN, 12'd255);
        send_item(8'h80, 8'h01, 8'hFF, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        wait_idle();

        // single column, zero gain passes the centre through
        write_reg(REG_FRAME_WIDTH, 12'd1);
        write_reg(REG_FRAME_HEIGHT, 12'd2);
        write_reg(REG_SHARPEN_GAIN, 12'd0);
        send_item(8'd10, 8'd20, 8'd30, 1'b0);
        send_item(8'd200, 8'd100, 8'd50, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        wait_idle();

        // random frames, mostly small
        phase_no   = 0;
        base_items = items_sent;
        while (items_sent - base_items < RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                raw_w = 0;
            end else if (sel < 65) begin
                raw_w = $urandom_range(1, 8);
            end else if (sel < 92) begin
                raw_w = $urandom_range(9, 32);
            end else begin
                raw_w = $urandom_range(33, 96);
            end
            sel = $urandom_range(99);
            if (sel < 5) begin
                raw_h = 0;
            end else if (sel < 70) begin
                raw_h = $urandom_range(1, 6);
            end else begin
                raw_h = $urandom_range(7, 16);
            end
            sel = $urandom_range(99);
            if (sel < 10) begin
                gain = 0;
            end else if (sel < 20) begin
                gain = 255;
            end else if (sel < 45) begin
                gain = $urandom_range(1, 4);
            end else begin
                gain = $urandom_range(255);
            end
            tone      = tone_t'($urandom_range(2));
            pause_mid = 1'b0;

            // long output hold-off while the input keeps offering
            if (phase_no == 0) begin
                raw_w = 8;
                raw_h = 6;
                hold_asks++;
            end
            // stretch with no idling on either side
            if (phase_no == 1) begin
                raw_w  = 10;
                raw_h  = 6;
                steady = 1'b1;
            end
            // let the pipeline empty in mid-frame
            if (phase_no == 2) begin
                raw_w     = 12;
                raw_h     = 6;
                pause_mid = 1'b1;
            end

            run_phase(raw_w, raw_h, gain, $urandom_range(1, 2), tone, pause_mid);
            steady = 1'b0;
            phase_no++;
        end

        // tall single column
        run_phase(1, 40, 3, 1, TONE_FLAT, 1'b0);

        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
